/* design/pq3_pkg.sv */
package pq3_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int LEVEL_DEPTH = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int TOP_LEVEL   = 2;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [DATA_WIDTH-1:0] entry_value;
        logic [1:0]            priority_req;
    } t_req;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] front_value;
        logic [DATA_WIDTH-1:0] back_value;
        logic                  is_empty;
        logic [1:0]            status;
    } t_res;

    typedef struct packed {
        logic exec;
        logic rd;
        logic load;
    } t_dp_cmd;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

/* design/pq3_ram.sv */
module pq3_ram #(
    parameter int WIDTH = pq3_pkg::DATA_WIDTH,
    parameter int DEPTH = 3 * pq3_pkg::LEVEL_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* design/pq3_ctrl.sv */
module pq3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_ready,
    output logic             o_ready,
    output logic             o_valid,
    output pq3_pkg::t_dp_cmd o_cmd
);

    pq3_pkg::t_state r_state;
    pq3_pkg::t_state n_state;

    assign o_ready = (r_state == pq3_pkg::S_IDLE);
    assign o_valid = (r_state == pq3_pkg::S_OUT);

    always_comb begin
        n_state    = r_state;
        o_cmd.exec = 1'b0;
        o_cmd.rd   = 1'b0;
        o_cmd.load = 1'b0;
        unique case (r_state)
            pq3_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = pq3_pkg::S_READ;
                end
            end
            pq3_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = pq3_pkg::S_LOAD;
            end
            pq3_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = pq3_pkg::S_OUT;
            end
            pq3_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = pq3_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pq3_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pq3_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/pq3_dp.sv */
module pq3_dp #(
    parameter int LEVEL_DEPTH = pq3_pkg::LEVEL_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pq3_pkg::t_dp_cmd i_cmd,
    input  pq3_pkg::t_req    i_req,
    output pq3_pkg::t_res    o_res
);

    localparam int NL    = pq3_pkg::NUM_LEVELS;
    localparam int DEPTH = NL * LEVEL_DEPTH;
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = pq3_pkg::DATA_WIDTH;

    logic [PW-1:0] r_head [NL];
    logic [PW-1:0] r_tail [NL];
    logic [CW-1:0] r_cnt  [NL];
    logic [PW-1:0] n_head [NL];
    logic [PW-1:0] n_tail [NL];
    logic [CW-1:0] n_cnt  [NL];

    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_any;
    pq3_pkg::t_res r_res;

    logic [1:0]    lvl;
    logic [1:0]    deq_lvl;
    logic          any_held;
    logic [1:0]    front_lvl;
    logic [1:0]    back_lvl;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] front_addr;
    logic [AW-1:0] back_addr;
    logic [DW-1:0] rd_front;
    logic [DW-1:0] rd_back;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        return (p == '0) ? PW'(LEVEL_DEPTH - 1) : p - PW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [1:0] l, input logic [PW-1:0] p);
        logic [AW-1:0] base;
        unique case (l)
            2'd0:    base = '0;
            2'd1:    base = AW'(LEVEL_DEPTH);
            default: base = AW'(2 * LEVEL_DEPTH);
        endcase
        return base + AW'(p);
    endfunction

    // saturate an out-of-range priority to the top level
    assign lvl = (i_req.priority_req > 2'(pq3_pkg::TOP_LEVEL)) ?
                 2'(pq3_pkg::TOP_LEVEL) : i_req.priority_req;

    assign any_held = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);

    always_comb begin
        priority if (r_cnt[2] != '0) begin
            front_lvl = 2'd2;
        end else if (r_cnt[1] != '0) begin
            front_lvl = 2'd1;
        end else begin
            front_lvl = 2'd0;
        end
    end

    always_comb begin
        priority if (r_cnt[0] != '0) begin
            back_lvl = 2'd0;
        end else if (r_cnt[1] != '0) begin
            back_lvl = 2'd1;
        end else begin
            back_lvl = 2'd2;
        end
    end

    assign deq_lvl = front_lvl;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_status = pq3_pkg::STAT_OK;
        wr_en    = 1'b0;
        if (i_cmd.exec) begin
            unique case (i_req.mode)
                pq3_pkg::MODE_ENQ: begin
                    if (r_cnt[lvl] == CW'(LEVEL_DEPTH)) begin
                        n_status = pq3_pkg::STAT_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        n_tail[lvl] = ring_next(r_tail[lvl]);
                        n_cnt[lvl]  = r_cnt[lvl] + CW'(1);
                    end
                end
                pq3_pkg::MODE_DEQ: begin
                    if (!any_held) begin
                        n_status = pq3_pkg::STAT_EMPTY;
                    end else begin
                        n_head[deq_lvl] = ring_next(r_head[deq_lvl]);
                        n_cnt[deq_lvl]  = r_cnt[deq_lvl] - CW'(1);
                    end
                end
                default: begin
                    // peek and the unused mode leave the levels alone
                end
            endcase
        end
    end

    assign wr_addr    = slot_of(lvl, r_tail[lvl]);
    assign front_addr = slot_of(front_lvl, r_head[front_lvl]);
    assign back_addr  = slot_of(back_lvl, ring_prev(r_tail[back_lvl]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.rd) begin
            r_any <= any_held;
        end
        if (i_cmd.load) begin
            r_res.front_value <= r_any ? rd_front : '0;
            r_res.back_value  <= r_any ? rd_back : '0;
            r_res.is_empty    <= !r_any;
            r_res.status      <= r_status;
        end
    end

    pq3_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (i_req.entry_value),
        .i_re      (i_cmd.rd),
        .i_raddr_a (front_addr),
        .i_raddr_b (back_addr),
        .o_rdata_a (rd_front),
        .o_rdata_b (rd_back)
    );

    assign o_res = r_res;

endmodule

/* design/three_level_priority_queue_unit.sv */
// Each result passes the level update, the registered store read and the output register
// before it is valid.
// Requests are handled one at a time: the next request is taken the cycle after the
// result is taken.
// Reset (synchronous, active low) empties all three levels; store contents stay as they are.
module three_level_priority_queue_unit #(
    parameter int LEVEL_DEPTH = pq3_pkg::LEVEL_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pq3_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output pq3_pkg::t_res o_res
);

    pq3_pkg::t_dp_cmd cmd;

    pq3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    pq3_dp #(
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

/* verif/testbench.sv */
module testbench;

    localparam int NUM_OPS      = 650;
    localparam int STALL_CYCLES = 150;

    logic          i_clk;
    logic          i_rst_n;
    logic          req_valid = 1'b0;
    logic          req_ready;
    pq3_pkg::t_req req       = '0;
    logic          res_valid;
    logic          res_ready;
    pq3_pkg::t_res res;

    three_level_priority_queue_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_req   (req),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_res   (res)
    );

    // Shadow queue state
    logic [pq3_pkg::DATA_WIDTH-1:0] slot_data [pq3_pkg::NUM_LEVELS][pq3_pkg::LEVEL_DEPTH];
    int head_idx [pq3_pkg::NUM_LEVELS] = '{default: 0};
    int tail_idx [pq3_pkg::NUM_LEVELS] = '{default: 0};
    int fill_cnt [pq3_pkg::NUM_LEVELS] = '{default: 0};

    pq3_pkg::t_req ops_to_send[$];
    pq3_pkg::t_res reports_due[$];

    int  n_total;
    int  n_sent     = 0;
    int  n_fail     = 0;
    bit  req_taken  = 1'b0;
    bit  drain_done = 1'b0;
    bit  stall_done = 1'b0;
    int  stall_left = 0;
    wire calm       = (n_sent >= 300) && (n_sent < 400);

    function automatic pq3_pkg::t_res apply_queue_op(input pq3_pkg::t_req op);
        pq3_pkg::t_res r;
        int            lvl;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        // priority 3 lands in the top level
        lvl = (op.priority_req > pq3_pkg::TOP_LEVEL) ? pq3_pkg::TOP_LEVEL
                                                     : int'(op.priority_req);
        r.status = pq3_pkg::STAT_OK;
        if (op.mode == pq3_pkg::MODE_ENQ) begin
            if (fill_cnt[lvl] >= pq3_pkg::LEVEL_DEPTH) begin
                r.status = pq3_pkg::STAT_FULL;
            end else begin
                slot_data[lvl][tail_idx[lvl]] = op.entry_value;
                tail_idx[lvl] = (tail_idx[lvl] + 1) % pq3_pkg::LEVEL_DEPTH;
                fill_cnt[lvl]++;
            end
        end else if (op.mode == pq3_pkg::MODE_DEQ) begin
            for (int i = pq3_pkg::TOP_LEVEL; i >= 0; i--) begin
                if (!hit && fill_cnt[i] != 0) begin
                    head_idx[i] = (head_idx[i] + 1) % pq3_pkg::LEVEL_DEPTH;
                    fill_cnt[i]--;
                    hit = 1'b1;
                end
            end
            if (!hit)
                r.status = pq3_pkg::STAT_EMPTY;
        end
        // ascending scan leaves the highest non-empty level as front
        r.is_empty = 1'b1;
        for (int i = 0; i <= pq3_pkg::TOP_LEVEL; i++) begin
            if (fill_cnt[i] != 0) begin
                r.front_value = slot_data[i][head_idx[i]];
                r.is_empty    = 1'b0;
            end
        end
        // descending scan leaves the lowest non-empty level as back
        for (int i = pq3_pkg::TOP_LEVEL; i >= 0; i--) begin
            if (fill_cnt[i] != 0)
                r.back_value = slot_data[i][(tail_idx[i] + pq3_pkg::LEVEL_DEPTH - 1)
                                            % pq3_pkg::LEVEL_DEPTH];
        end
        return r;
    endfunction

    function automatic logic [pq3_pkg::DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input logic [1:0] mode,
                           input logic [pq3_pkg::DATA_WIDTH-1:0] value,
                           input logic [1:0] prio);
        pq3_pkg::t_req op;
        op.mode         = mode;
        op.entry_value  = value;
        op.priority_req = prio;
        ops_to_send.push_back(op);
    endtask

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (req_taken || !req_valid)) begin
            req_taken = 1'b0;
            if (n_sent >= 480 && !drain_done) begin
                // hold off until every report is back
                req_valid <= 1'b0;
                if (reports_due.size() == 0)
                    drain_done = 1'b1;
            end else if (ops_to_send.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                req_valid <= 1'b1;
                req       <= ops_to_send.pop_front();
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else if (stall_left != 0) begin
            res_ready <= 1'b0;
            stall_left--;
        end else if (!stall_done && n_sent >= 120) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            res_ready <= 1'b0;
        end else begin
            res_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        pq3_pkg::t_res want;
        if (i_rst_n && res_valid && res_ready) begin
            if (reports_due.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result: front %h back %h empty %b status %0d",
                             res.front_value, res.back_value, res.is_empty, res.status);
            end else begin
                want = reports_due.pop_front();
                if (res.front_value !== want.front_value || res.back_value !== want.back_value
                    || res.is_empty !== want.is_empty || res.status !== want.status) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch exp/got: front %h/%h back %h/%h empty %b/%b st %0d/%0d",
                                 want.front_value, res.front_value,
                                 want.back_value, res.back_value,
                                 want.is_empty, res.is_empty, want.status, res.status);
                end
            end
        end
        if (i_rst_n && req_valid && req_ready) begin
            reports_due.push_back(apply_queue_op(req));
            n_sent++;
            req_taken = 1'b1;
        end
    end

    initial begin
        int kind;
        int len;
        int lvl;
        i_rst_n = 1'b0;

        // empty queue: dequeue, peek, unused mode
        push_op(pq3_pkg::MODE_DEQ, '1, 2'd0);
        push_op(pq3_pkg::MODE_PEEK, '0, 2'd3);
        push_op(2'd3, '1, 2'd1);
        // saturated priority, extreme values
        push_op(pq3_pkg::MODE_ENQ, '1, 2'd3);
        push_op(pq3_pkg::MODE_ENQ, '0, 2'd1);
        // fill level 0 and overflow it once
        for (int i = 0; i <= pq3_pkg::LEVEL_DEPTH; i++)
            push_op(pq3_pkg::MODE_ENQ, pick_value(), 2'd0);
        push_op(2'd3, '0, 2'd2);
        push_op(pq3_pkg::MODE_DEQ, '0, 2'd0);
        push_op(pq3_pkg::MODE_DEQ, '1, 2'd3);

        while (ops_to_send.size() < NUM_OPS) begin
            kind = $urandom_range(9);
            if (kind < 3) begin
                lvl = $urandom_range(3);
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    push_op(pq3_pkg::MODE_ENQ, pick_value(), lvl[1:0]);
            end else if (kind < 5) begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    push_op(pq3_pkg::MODE_DEQ, pick_value(), 2'($urandom_range(3)));
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    push_op(2'($urandom_range(3)), pick_value(), 2'($urandom_range(3)));
            end
        end
        n_total = ops_to_send.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (n_sent == n_total);
        wait (reports_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (reports_due.size() != 0)
            n_fail++;
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* three_level_priority_queue_unit.f */
design/pq3_pkg.sv
design/pq3_ram.sv
design/pq3_ctrl.sv
design/pq3_dp.sv
design/three_level_priority_queue_unit.sv
verif/testbench.sv
